/* hw/rtl/predecrement_address_sequencer_defines.svh */
// Assertion macros used by the checker file of the address sequencer
`ifndef PREDECREMENT_ADDRESS_SEQUENCER_DEFINES_SVH
`define PREDECREMENT_ADDRESS_SEQUENCER_DEFINES_SVH

// Checked on every clock edge outside reset
`define PDAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define PDAS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/pdas_pkg.sv */
// Types, constants and codes of the pre-decrement address sequencer
package pdas_pkg;

    localparam int ADDR_W  = 32;
    localparam int MASK_W  = 16;
    localparam int REG_W   = 3;
    localparam int SIZE_W  = 3;
    localparam int SRC_W   = 4;
    localparam int CYC_W   = 10;
    localparam int CFG_W   = 6;
    localparam int BIT_W   = 4;

    typedef enum logic {
        REQ_SINGLE = 1'b0,
        REQ_LIST   = 1'b1
    } t_req_type;

    typedef enum logic {
        CFG_SHORT_CYCLES = 1'b0,
        CFG_LONG_CYCLES  = 1'b1
    } t_cfg_idx;

    localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_LONG = 3'd4;

    localparam logic [REG_W-1:0] STACK_REG    = 3'd7;
    localparam logic [SRC_W-1:0] TOP_SRC      = 4'd15;
    localparam logic [CFG_W-1:0] SHORT_RST    = 6'd6;
    localparam logic [CFG_W-1:0] LONG_RST     = 6'd10;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
        logic last;
    } t_dp_sts;

    typedef struct packed {
        logic              access_valid;
        logic              access_is_read;
        logic [ADDR_W-1:0] access_address;
        logic [SIZE_W-1:0] access_bytes;
        logic [SRC_W-1:0]  source_reg;
        logic [ADDR_W-1:0] new_reg_value;
        logic [CYC_W-1:0]  cycle_count;
        logic              last;
    } t_res;

endpackage

/* hw/rtl/pdas_req_if.sv */
// Request channel: valid/ready handshake with the request fields
interface pdas_req_if import pdas_pkg::*;;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [REG_W-1:0]  reg_num;
    logic [SIZE_W-1:0] op_size;
    logic [ADDR_W-1:0] base_address;
    logic [MASK_W-1:0] reg_mask;

    modport source (output valid, req_type, reg_num, op_size, base_address, reg_mask,
                    input ready);
    modport sink   (input valid, req_type, reg_num, op_size, base_address, reg_mask,
                    output ready);
endinterface

/* hw/rtl/pdas_res_if.sv */
// Result channel: valid/ready handshake with the access fields
interface pdas_res_if import pdas_pkg::*;;
    logic              valid;
    logic              ready;
    logic              access_valid;
    logic              access_is_read;
    logic [ADDR_W-1:0] access_address;
    logic [SIZE_W-1:0] access_bytes;
    logic [SRC_W-1:0]  source_reg;
    logic [ADDR_W-1:0] new_reg_value;
    logic [CYC_W-1:0]  cycle_count;
    logic              last;

    modport source (output valid, access_valid, access_is_read, access_address,
                    access_bytes, source_reg, new_reg_value, cycle_count, last,
                    input ready);
    modport sink   (input valid, access_valid, access_is_read, access_address,
                    access_bytes, source_reg, new_reg_value, cycle_count, last,
                    output ready);
endinterface

/* hw/rtl/predecrement_address_sequencer.sv */
// Top level of the pre-decrement address sequencer (-(An) and register-list store)
//
// Usage notes:
//  - i_req: request transfer (valid/ready). req_type selects a single pre-decrement
//    read or a register-list store walking reg_mask from bit 0 (A7) up to bit 15 (D0).
//  - o_res: one result per transfer. Single read and empty list: one result. List
//    store: one write per set mask bit, in mask order. last marks the final result,
//    which alone carries new_reg_value and cycle_count.
//  - Config: i_cfg_we/i_cfg_idx/i_cfg_data write short_cycles (0) or long_cycles (1).
//    Write only while idle; no read-back.
//  - The request transfer loads the working registers; the first result is then
//    registered once the result register is free. Each request gives 1..16 results.
//    The controller steps the datapath's working address and mask once per result;
//    ready is high only while the controller sits idle.
//  - A finished result sits in the output register while the next request is
//    taken; the datapath only advances when that register is free or drained.
//  - Receiver stall: results hold steady, the sequence pauses and resumes intact.
//  - Reset (synchronous, active low): controller idle, no result pending,
//    short_cycles = 6, long_cycles = 10.
module predecrement_address_sequencer import pdas_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pdas_req_if.sink         i_req,
    pdas_res_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    res_valid;
    t_res    res;

    pdas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pdas_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req.req_type),
        .i_reg_num      (i_req.reg_num),
        .i_op_size      (i_req.op_size),
        .i_base_address (i_req.base_address),
        .i_reg_mask     (i_req.reg_mask),
        .i_res_ready    (o_res.ready),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    // result register straight onto the channel
    assign o_res.valid          = res_valid;
    assign o_res.access_valid   = res.access_valid;
    assign o_res.access_is_read = res.access_is_read;
    assign o_res.access_address = res.access_address;
    assign o_res.access_bytes   = res.access_bytes;
    assign o_res.source_reg     = res.source_reg;
    assign o_res.new_reg_value  = res.new_reg_value;
    assign o_res.cycle_count    = res.cycle_count;
    assign o_res.last           = res.last;

endmodule

/* hw/rtl/pdas_ctrl.sv */
// Sequencer controller: accepts a request, then steps the datapath once per result
module pdas_ctrl import pdas_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
                if (i_req_valid) begin
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                o_cmd.emit = i_sts.slot_free;
                if (i_sts.slot_free && i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/pdas_dp.sv */
// Sequencer datapath: config registers, working address/mask, result register
module pdas_dp import pdas_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_req_type,
    input  logic [REG_W-1:0]  i_reg_num,
    input  logic [SIZE_W-1:0] i_op_size,
    input  logic [ADDR_W-1:0] i_base_address,
    input  logic [MASK_W-1:0] i_reg_mask,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output t_res              o_res
);

    logic [CFG_W-1:0]  r_short;
    logic [CFG_W-1:0]  r_long;
    logic              r_type;
    logic [ADDR_W-1:0] r_addr;
    logic [MASK_W-1:0] r_mask;
    logic [SIZE_W-1:0] r_bytes;
    logic [SIZE_W-1:0] r_dec;
    logic [CYC_W-1:0]  r_cyc;
    logic              r_res_valid;
    t_res              r_res;

    logic [SIZE_W-1:0] ld_bytes;
    logic [SIZE_W-1:0] ld_dec;
    logic [CFG_W-1:0]  cost;
    logic [ADDR_W-1:0] n_addr;
    logic [MASK_W-1:0] low_bit;
    logic [MASK_W-1:0] n_mask;
    logic [BIT_W-1:0]  bit_idx;
    logic [CYC_W-1:0]  n_cyc;
    logic              last;
    t_res              n_res;

    // Access size and decrement, fixed at load
    always_comb begin
        if (t_req_type'(i_req_type) == REQ_SINGLE) begin
            ld_bytes = (i_op_size == SIZE_BYTE || i_op_size == SIZE_WORD) ? i_op_size
                                                                          : SIZE_LONG;
            // byte access through the stack pointer keeps it word aligned
            ld_dec   = (ld_bytes == SIZE_BYTE && i_reg_num == STACK_REG) ? SIZE_WORD
                                                                         : ld_bytes;
        end else begin
            ld_bytes = (i_op_size == SIZE_WORD) ? SIZE_WORD : SIZE_LONG;
            ld_dec   = ld_bytes;
        end
    end

    assign cost    = (r_bytes == SIZE_LONG) ? r_long : r_short;
    assign n_addr  = r_addr - {{(ADDR_W-SIZE_W){1'b0}}, r_dec};
    assign low_bit = r_mask & (~r_mask + {{(MASK_W-1){1'b0}}, 1'b1});
    assign n_mask  = r_mask & ~low_bit;
    assign n_cyc   = r_cyc + {{(CYC_W-CFG_W){1'b0}}, cost};

    always_comb begin
        bit_idx = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (low_bit[i]) begin
                bit_idx = bit_idx | BIT_W'(i);
            end
        end
    end

    assign last = (t_req_type'(r_type) == REQ_SINGLE) || (n_mask == '0);

    always_comb begin
        n_res = '0;
        if (t_req_type'(r_type) == REQ_SINGLE) begin
            n_res.access_valid   = 1'b1;
            n_res.access_is_read = 1'b1;
            n_res.access_address = n_addr;
            n_res.access_bytes   = r_bytes;
            n_res.new_reg_value  = n_addr;
            n_res.cycle_count    = {{(CYC_W-CFG_W){1'b0}}, cost};
            n_res.last           = 1'b1;
        end else if (r_mask == '0) begin
            // empty list: no access, register unchanged
            n_res.new_reg_value  = r_addr;
            n_res.last           = 1'b1;
        end else begin
            n_res.access_valid   = 1'b1;
            n_res.access_address = n_addr;
            n_res.access_bytes   = r_bytes;
            n_res.source_reg     = TOP_SRC - bit_idx;
            n_res.last           = last;
            n_res.new_reg_value  = last ? n_addr : '0;
            n_res.cycle_count    = last ? n_cyc : '0;
        end
    end

    assign o_sts.slot_free = !r_res_valid || i_res_ready;
    assign o_sts.last      = last;
    assign o_res_valid     = r_res_valid;
    assign o_res           = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short     <= SHORT_RST;
            r_long      <= LONG_RST;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_SHORT_CYCLES) begin
                    r_short <= i_cfg_data;
                end else begin
                    r_long <= i_cfg_data;
                end
            end
            if (i_cmd.emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_req_type;
            r_addr  <= i_base_address;
            r_mask  <= i_reg_mask;
            r_bytes <= ld_bytes;
            r_dec   <= ld_dec;
            r_cyc   <= '0;
        end else if (i_cmd.emit) begin
            r_addr  <= n_addr;
            r_mask  <= n_mask;
            r_cyc   <= n_cyc;
        end
        if (i_cmd.emit) begin
            r_res <= n_res;
        end
    end

endmodule

/* hw/rtl/pdas_chk.sv */
// Port-level checker of the address sequencer, bound to the top level
`include "predecrement_address_sequencer_defines.svh"

module pdas_chk import pdas_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_access_valid,
    input logic [ADDR_W-1:0] i_out_address,
    input logic [ADDR_W-1:0] i_out_new_reg_value,
    input logic [CYC_W-1:0]  i_out_cycle_count,
    input logic              i_out_last
);

    `PDAS_ASSERT(a_stall_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_address) && $stable(i_out_last), "stalled result changed")
    `PDAS_ASSERT(a_busy_after_req, i_in_valid && i_in_ready |=> !i_in_ready, "request taken while busy")
    `PDAS_ASSERT(a_mid_zero, i_out_valid && !i_out_last |-> i_out_new_reg_value == '0 && i_out_cycle_count == '0, "totals on non-final result")
    `PDAS_ASSERT(a_empty_last, i_out_valid && !i_out_access_valid |-> i_out_last && i_out_cycle_count == '0, "empty result not final")
    `PDAS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !i_out_valid, "result pending after reset")

endmodule

bind predecrement_address_sequencer pdas_chk u_pdas_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_req.valid),
    .i_in_ready          (i_req.ready),
    .i_out_valid         (o_res.valid),
    .i_out_ready         (o_res.ready),
    .i_out_access_valid  (o_res.access_valid),
    .i_out_address       (o_res.access_address),
    .i_out_new_reg_value (o_res.new_reg_value),
    .i_out_cycle_count   (o_res.cycle_count),
    .i_out_last          (o_res.last)
);

/* bench/tb.sv */
// Self-checking bench for the pre-decrement address sequencer
`timescale 1ns / 1ps

module tb import pdas_pkg::*;;

    // Slowest legal run is well under this: ~500 requests, up to 16 results each,
    // each result possibly held off by the receiver.
    localparam int CYCLE_LIMIT = 800_000;
    localparam int SHOW_MAX    = 10;

    // ------------------------------------------------------------------
    // Scoreboard: predicts the access sequence of each request transfer
    // and checks result transfers against it in order.
    // ------------------------------------------------------------------
    class access_scoreboard;
        t_res              access_q[$];
        logic [CFG_W-1:0]  short_cost;
        logic [CFG_W-1:0]  long_cost;
        int                errors;

        function new();
            short_cost = SHORT_RST;
            long_cost  = LONG_RST;
            errors     = 0;
        endfunction

        function void set_cost(t_cfg_idx idx, logic [CFG_W-1:0] val);
            if (idx == CFG_SHORT_CYCLES) begin
                short_cost = val;
            end else begin
                long_cost = val;
            end
        endfunction

        function int pending();
            return access_q.size();
        endfunction

        // Append one predicted result at the tail
        function void add_expected(t_res r);
            access_q = {access_q, r};
        endfunction

        // Expand one accepted request into the results it should produce
        function void note_request(t_req_type kind, logic [REG_W-1:0] areg,
                                   logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] base,
                                   logic [MASK_W-1:0] mask);
            t_res              r;
            logic [ADDR_W-1:0] addr;
            logic [ADDR_W-1:0] step;
            logic [SIZE_W-1:0] bytes;
            logic [CFG_W-1:0]  cost;
            int                total;
            int                n;
            addr = base;
            r    = '0;
            if (kind == REQ_SINGLE) begin
                // byte/word as given, anything else is a long
                bytes = (size == SIZE_BYTE || size == SIZE_WORD) ? size : SIZE_LONG;
                // byte through the stack pointer keeps A7 word aligned
                step  = (bytes == SIZE_BYTE && areg == STACK_REG) ? ADDR_W'(SIZE_WORD)
                                                                  : ADDR_W'(bytes);
                cost  = (bytes == SIZE_LONG) ? long_cost : short_cost;
                addr  = addr - step;
                r.access_valid   = 1'b1;
                r.access_is_read = 1'b1;
                r.access_address = addr;
                r.access_bytes   = bytes;
                r.new_reg_value  = addr;
                r.cycle_count    = CYC_W'(cost);
                r.last           = 1'b1;
                add_expected(r);
            end else begin
                bytes = (size == SIZE_WORD) ? SIZE_WORD : SIZE_LONG;
                cost  = (bytes == SIZE_LONG) ? long_cost : short_cost;
                total = $countones(mask);
                if (total == 0) begin
                    // empty list: a single marker result, register unchanged
                    r.new_reg_value = base;
                    r.last          = 1'b1;
                    add_expected(r);
                end else begin
                    n = 0;
                    for (int b = 0; b < MASK_W; b++) begin
                        if (mask[b]) begin
                            addr = addr - ADDR_W'(bytes);
                            n++;
                            r                = '0;
                            r.access_valid   = 1'b1;
                            r.access_address = addr;
                            r.access_bytes   = bytes;
                            r.source_reg     = TOP_SRC - SRC_W'(b);
                            if (n == total) begin
                                r.new_reg_value = addr;
                                r.cycle_count   = CYC_W'(int'(cost) * total);
                                r.last          = 1'b1;
                            end
                            add_expected(r);
                        end
                    end
                end
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (access_q.size() == 0) begin
                errors++;
                if (errors <= SHOW_MAX) begin
                    $display("unexpected result: addr %08h src %0d last %0b",
                             got.access_address, got.source_reg, got.last);
                end
            end else begin
                want = access_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= SHOW_MAX) begin
                        $display("mismatch exp: v%0b rd%0b a%08h b%0d s%0d nv%08h c%0d l%0b",
                                 want.access_valid, want.access_is_read,
                                 want.access_address, want.access_bytes, want.source_reg,
                                 want.new_reg_value, want.cycle_count, want.last);
                        $display("         got: v%0b rd%0b a%08h b%0d s%0d nv%08h c%0d l%0b",
                                 got.access_valid, got.access_is_read,
                                 got.access_address, got.access_bytes, got.source_reg,
                                 got.new_reg_value, got.cycle_count, got.last);
                    end
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block itself
    // ------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    int               send_idle;   // percent of cycles the request side holds off
    int               recv_idle;   // percent of cycles the result side stalls

    access_scoreboard sb;

    pdas_req_if req_if ();
    pdas_res_if res_if ();

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    predecrement_address_sequencer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // One request transfer. valid is only lowered on an idle cycle, so
    // back-to-back transfers keep it high without a same-step glitch.
    task automatic send_req(t_req_type kind, logic [REG_W-1:0] areg,
                            logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] base,
                            logic [MASK_W-1:0] mask);
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.reg_num      <= areg;
        req_if.op_size      <= size;
        req_if.base_address <= base;
        req_if.reg_mask     <= mask;
        do @(posedge clk); while (!req_if.ready);
        sb.note_request(kind, areg, size, base, mask);
    endtask

    // Random request: sizes biased to the legal ones, addresses biased towards
    // the wrap points, masks mixing empty, full, single-bit and random lists.
    task automatic random_requests(int count);
        t_req_type         kind;
        logic [REG_W-1:0]  areg;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] base;
        logic [MASK_W-1:0] mask;
        int                pick;
        repeat (count) begin
            kind = t_req_type'($urandom_range(1));
            areg = REG_W'($urandom_range(7));
            pick = $urandom_range(9);
            if (pick < 3) begin
                size = SIZE_BYTE;
            end else if (pick < 6) begin
                size = SIZE_WORD;
            end else if (pick < 9) begin
                size = SIZE_LONG;
            end else begin
                size = SIZE_W'($urandom_range(7));
            end
            pick = $urandom_range(7);
            if (pick == 0) begin
                base = ADDR_W'($urandom_range(63));
            end else if (pick == 1) begin
                base = 32'hFFFF_FFFF - ADDR_W'($urandom_range(63));
            end else begin
                base = $urandom();
            end
            pick = $urandom_range(9);
            if (pick == 0) begin
                mask = '0;
            end else if (pick == 1) begin
                mask = '1;
            end else if (pick < 4) begin
                mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
            end else begin
                mask = MASK_W'($urandom());
            end
            send_req(kind, areg, size, base, mask);
        end
    endtask

    // Drop valid and wait for every predicted result, then let the controller
    // return to idle before any register write.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Both cost registers, short then long, written while idle
    task automatic set_costs(logic [CFG_W-1:0] short_val, logic [CFG_W-1:0] long_val);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SHORT_CYCLES;
        cfg_data <= short_val;
        @(posedge clk);
        cfg_idx  <= CFG_LONG_CYCLES;
        cfg_data <= long_val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_cost(CFG_SHORT_CYCLES, short_val);
        sb.set_cost(CFG_LONG_CYCLES, long_val);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, every result transfer checked in order
    // ------------------------------------------------------------------
    initial begin
        t_res got;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) begin
                got.access_valid   = res_if.access_valid;
                got.access_is_read = res_if.access_is_read;
                got.access_address = res_if.access_address;
                got.access_bytes   = res_if.access_bytes;
                got.source_reg     = res_if.source_reg;
                got.new_reg_value  = res_if.new_reg_value;
                got.cycle_count    = res_if.cycle_count;
                got.last           = res_if.last;
                sb.check_result(got);
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        sb        = new();
        send_idle = 11;
        recv_idle = 64;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_SHORT_CYCLES;
        cfg_data            <= '0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= REQ_SINGLE;
        req_if.reg_num      <= '0;
        req_if.op_size      <= SIZE_BYTE;
        req_if.base_address <= '0;
        req_if.reg_mask     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset costs. Single reads: every size code, the
        // stack-pointer byte case, and wrap below zero.
        send_req(REQ_SINGLE, 3'd0, SIZE_BYTE, 32'h0000_0000, 16'h0000);
        send_req(REQ_SINGLE, STACK_REG, SIZE_BYTE, 32'h0000_1000, 16'hFFFF);
        send_req(REQ_SINGLE, STACK_REG, SIZE_BYTE, 32'h0000_0001, 16'h0000);
        send_req(REQ_SINGLE, STACK_REG, SIZE_WORD, 32'h0000_1000, 16'h0000);
        send_req(REQ_SINGLE, STACK_REG, SIZE_LONG, 32'h0000_0002, 16'h0000);
        send_req(REQ_SINGLE, 3'd5, SIZE_WORD, 32'hFFFF_FFFF, 16'h0000);
        send_req(REQ_SINGLE, 3'd2, SIZE_LONG, 32'hFFFF_FFFF, 16'h0000);
        send_req(REQ_SINGLE, 3'd1, 3'd0, 32'h8000_0000, 16'h0000);
        send_req(REQ_SINGLE, 3'd4, 3'd3, 32'h0000_0003, 16'h0000);
        send_req(REQ_SINGLE, 3'd6, 3'd5, 32'h1234_5678, 16'h0000);
        send_req(REQ_SINGLE, 3'd6, 3'd6, 32'h1234_5678, 16'h0000);
        send_req(REQ_SINGLE, 3'd6, 3'd7, 32'h1234_5678, 16'h0000);
        // Register-list stores: full, empty, single ends, alternating, odd sizes
        send_req(REQ_LIST, STACK_REG, SIZE_WORD, 32'h0000_0000, 16'hFFFF);
        send_req(REQ_LIST, 3'd0, SIZE_LONG, 32'hFFFF_FFFF, 16'hFFFF);
        send_req(REQ_LIST, 3'd3, SIZE_LONG, 32'hDEAD_BEEF, 16'h0000);
        send_req(REQ_LIST, 3'd1, SIZE_WORD, 32'h0000_0100, 16'h0001);
        send_req(REQ_LIST, 3'd1, SIZE_WORD, 32'h0000_0100, 16'h8000);
        send_req(REQ_LIST, 3'd2, SIZE_LONG, 32'h0000_0010, 16'hAAAA);
        send_req(REQ_LIST, 3'd2, SIZE_LONG, 32'h0000_0010, 16'h5555);
        send_req(REQ_LIST, STACK_REG, SIZE_BYTE, 32'h0000_2000, 16'h00F0);
        send_req(REQ_LIST, 3'd4, 3'd0, 32'h0000_0004, 16'h0F00);
        send_req(REQ_LIST, 3'd5, 3'd7, 32'h7FFF_FFFF, 16'h8001);
        settle();

        // Sender mostly busy, receiver stalling often
        set_costs(6'd63, 6'd0);
        random_requests(160);
        settle();

        // And the other way round
        send_idle = 64;
        recv_idle = 11;
        set_costs(6'd0, 6'd63);
        random_requests(160);
        settle();

        // No idling: back-to-back transfers, several cost settings
        send_idle = 0;
        recv_idle = 0;
        set_costs(CFG_W'($urandom()), CFG_W'($urandom()));
        random_requests(60);
        settle();
        set_costs(6'd63, 6'd63);   // largest cycle totals
        random_requests(60);
        settle();
        set_costs(6'd0, 6'd0);
        random_requests(40);
        settle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
